/* rtl/mbar_pkg.sv */
// shared types and constants for the modbus ascii frame receiver
`timescale 1ns / 1ps

package mbar_pkg;

   localparam int IDX_W = 5;

   localparam logic [1:0] ST_ACCEPT   = 2'd0;
   localparam logic [1:0] ST_TOO_LONG = 2'd1;
   localparam logic [1:0] ST_BUSY     = 2'd2;

   localparam logic CSR_STATION = 1'b0;
   localparam logic CSR_ENABLE  = 1'b1;

   typedef struct packed {
      logic       func;
      logic [7:0] rx_char;
      logic       busy_req;
   } req_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [7:0]       command;
      logic [7:0]       data_byte;
      logic [IDX_W-1:0] data_index;
      logic [IDX_W-1:0] data_count;
      logic             byte_valid;
      logic             last;
   } rsp_type;

   typedef enum logic [1:0] {
      CMD_WRITE,
      CMD_EXC,
      CMD_RUN
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type     kind;
      logic [1:0]       status;
      logic [7:0]       command;
      logic [7:0]       data;
      logic [IDX_W-1:0] idx;
   } cmd_type;

   typedef enum logic {
      BK_IDLE,
      BK_RUN
   } back_state_type;

endpackage

/* rtl/mbar_front.sv */
// character decoder and framer: tracks frame position, lrc and data count
`timescale 1ns / 1ps

module mbar_front #(
   parameter int DATA_DEPTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   input  mbar_pkg::req_type req_data,
   input  logic             q_full,
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [7:0]       csr_wdata,
   output logic             q_push,
   output mbar_pkg::cmd_type q_entry
);
   import mbar_pkg::*;

   localparam int CW = $clog2(DATA_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(DATA_DEPTH);

   localparam logic [3:0] PH_IDLE     = 4'd0;
   localparam logic [3:0] PH_START    = 4'd1;
   localparam logic [3:0] PH_ADDR     = 4'd3;
   localparam logic [3:0] PH_CMD      = 4'd5;
   localparam logic [3:0] PH_DATA     = 4'd6;
   localparam logic [3:0] PH_BEYOND   = 4'd9;
   localparam logic [7:0] CH_COLON    = 8'h3a;
   localparam logic [7:0] CH_CR       = 8'h0d;
   localparam logic [7:0] CH_LF       = 8'h0a;

   function automatic logic [7:0] nibble_of(input logic [7:0] c);
      if (c < 8'h41) begin
         return c & 8'h0f;
      end
      return c - 8'h41 + 8'h0a;
   endfunction

   logic [7:0]    station_ff, station_in;
   logic          enable_ff, enable_in;
   logic [3:0]    phase_ff, phase_in;
   logic          parity_ff, parity_in;
   logic [7:0]    last_ff, last_in;
   logic [7:0]    pair_ff, pair_in;
   logic [7:0]    prior_ff, prior_in;
   logic [7:0]    lrc_ff, lrc_in;
   logic [CW-1:0] count_ff, count_in;
   logic [7:0]    command_ff, command_in;
   logic          pending_ff, pending_in;

   logic          accept;
   logic [7:0]    ch;
   logic [3:0]    ph;
   logic          par;
   logic [7:0]    pair;
   logic [7:0]    prior;
   logic [7:0]    pair_calc;
   logic [7:0]    sum;
   logic          lrc_ok;
   logic          eol_pair;
   logic [CW-1:0] count_dec;

   assign accept    = req_push && !q_full;
   assign ch        = req_data.rx_char;
   assign pair_calc = (nibble_of(last_ff) << 4) | nibble_of(ch);
   assign eol_pair  = (ch == CH_CR || ch == CH_LF) && (last_ff == CH_CR || last_ff == CH_LF);
   assign prior     = parity_ff ? prior_ff : pair_ff;
   assign sum       = lrc_ff - prior;
   assign lrc_ok    = prior == (8'd0 - sum);
   assign count_dec = (count_ff != '0) ? count_ff - CW'(1) : count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         station_ff <= '0;
         enable_ff  <= 1'b0;
         phase_ff   <= PH_IDLE;
         parity_ff  <= 1'b0;
         last_ff    <= '0;
         pair_ff    <= '0;
         prior_ff   <= '0;
         lrc_ff     <= '0;
         count_ff   <= '0;
         command_ff <= 8'hff;
         pending_ff <= 1'b0;
      end else begin
         station_ff <= station_in;
         enable_ff  <= enable_in;
         phase_ff   <= phase_in;
         parity_ff  <= parity_in;
         last_ff    <= last_in;
         pair_ff    <= pair_in;
         prior_ff   <= prior_in;
         lrc_ff     <= lrc_in;
         count_ff   <= count_in;
         command_ff <= command_in;
         pending_ff <= pending_in;
      end
   end

   always_comb begin
      station_in = station_ff;
      enable_in  = enable_ff;
      phase_in   = phase_ff;
      parity_in  = parity_ff;
      last_in    = last_ff;
      pair_in    = pair_ff;
      prior_in   = prior_ff;
      lrc_in     = lrc_ff;
      count_in   = count_ff;
      command_in = command_ff;
      pending_in = pending_ff;
      q_push     = 1'b0;
      q_entry    = '0;
      ph         = (phase_ff < PH_BEYOND) ? phase_ff + 4'd1 : phase_ff;
      par        = ~parity_ff;
      pair       = par ? pair_calc : pair_ff;

      if (csr_we) begin
         case (csr_index)
            CSR_STATION: station_in = csr_wdata;
            CSR_ENABLE:  enable_in  = csr_wdata[0];
            default:     station_in = station_ff;
         endcase
      end

      if (accept) begin
         if (req_data.func) begin
            pending_in = 1'b0;
         end else if (!pending_ff && enable_ff) begin
            if (ch == CH_COLON) begin
               phase_in  = PH_START;
               parity_in = 1'b1;
               count_in  = '0;
               lrc_in    = '0;
            end else if (phase_ff != PH_IDLE) begin
               if (ph == PH_ADDR) begin
                  if (pair != station_ff) begin
                     ph = PH_IDLE;
                  end
               end else if (ph == PH_CMD) begin
                  command_in = pair;
               end else if (ph >= PH_DATA) begin
                  if (ph == PH_BEYOND && eol_pair) begin
                     if (lrc_ok) begin
                        q_push          = 1'b1;
                        q_entry.command = command_ff;
                        if (count_ff >= DEPTH_C) begin
                           q_entry.kind   = CMD_EXC;
                           q_entry.status = ST_TOO_LONG;
                        end else if (req_data.busy_req) begin
                           q_entry.kind   = CMD_EXC;
                           q_entry.status = ST_BUSY;
                        end else begin
                           q_entry.kind   = CMD_RUN;
                           q_entry.status = ST_ACCEPT;
                           q_entry.idx    = IDX_W'(count_dec);
                           pending_in     = 1'b1;
                           count_in       = count_dec;
                        end
                     end else begin
                        count_in = '0;
                     end
                     ph  = PH_IDLE;
                     par = 1'b0;
                  end else if (par && count_ff < DEPTH_C) begin
                     q_push       = 1'b1;
                     q_entry.kind = CMD_WRITE;
                     q_entry.data = pair;
                     q_entry.idx  = IDX_W'(count_ff);
                     count_in     = count_ff + CW'(1);
                  end
               end
               phase_in  = ph;
               parity_in = par;
               pair_in   = pair;
               prior_in  = prior;
               if (ph != PH_IDLE && par) begin
                  lrc_in = lrc_ff + pair;
               end
               last_in = ch;
            end
         end
      end
   end

endmodule

/* rtl/mbar_cmd_queue.sv */
// short command queue between the framer and the result sequencer
`timescale 1ns / 1ps

module mbar_cmd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  mbar_pkg::cmd_type push_data,
   input  logic              pop,
   output logic              full,
   output logic              empty,
   output mbar_pkg::cmd_type head
);
   import mbar_pkg::*;

   localparam int DEPTH = 4;
   localparam int PW    = $clog2(DEPTH);

   cmd_type       slot_ff [DEPTH];
   logic [PW-1:0] wr_ff, wr_in;
   logic [PW-1:0] rd_ff, rd_in;
   logic [PW:0]   cnt_ff, cnt_in;
   logic          do_push;
   logic          do_pop;

   assign full    = cnt_ff == (PW + 1)'(DEPTH);
   assign empty   = cnt_ff == '0;
   assign head    = slot_ff[rd_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_in  = do_push ? wr_ff + PW'(1) : wr_ff;
      rd_in  = do_pop ? rd_ff + PW'(1) : rd_ff;
      cnt_in = cnt_ff + (PW + 1)'(do_push) - (PW + 1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

endmodule

/* rtl/mbar_back.sv */
// result sequencer: data store writes, exceptions and the run of stored bytes
`timescale 1ns / 1ps

module mbar_back #(
   parameter int DATA_DEPTH = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   input  mbar_pkg::cmd_type q_head,
   output logic              q_pop,
   input  logic              rsp_pop,
   output logic              rsp_empty,
   output mbar_pkg::rsp_type rsp_data
);
   import mbar_pkg::*;

   localparam int AW = $clog2(DATA_DEPTH);

   logic [7:0]       mem [DATA_DEPTH];
   logic [7:0]       rd_data_ff;

   back_state_type   state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] cnt_ff, cnt_in;
   logic [7:0]       cmd_ff, cmd_in;
   logic             rd_pend_ff, rd_pend_in;
   logic             out_valid_ff, out_valid_in;
   rsp_type          out_ff, out_in;

   logic             out_free;
   logic             mem_we;
   logic             mem_re;
   logic             run_last;

   assign out_free  = !out_valid_ff || rsp_pop;
   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;
   assign run_last  = ({1'b0, idx_ff} + (IDX_W + 1)'(1)) == {1'b0, cnt_ff};

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[q_head.idx[AW-1:0]] <= q_head.data;
      end
      if (mem_re) begin
         rd_data_ff <= mem[idx_ff[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rd_pend_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_pend_ff   <= rd_pend_in;
         out_valid_ff <= out_valid_in;
      end
      idx_ff <= idx_in;
      cnt_ff <= cnt_in;
      cmd_ff <= cmd_in;
      out_ff <= out_in;
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      cmd_in       = cmd_ff;
      rd_pend_in   = rd_pend_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      out_in       = out_ff;
      q_pop        = 1'b0;
      mem_we       = 1'b0;
      mem_re       = 1'b0;

      case (state_ff)
         BK_IDLE: begin
            if (!q_empty) begin
               case (q_head.kind)
                  CMD_WRITE: begin
                     mem_we = 1'b1;
                     q_pop  = 1'b1;
                  end
                  CMD_EXC: begin
                     if (out_free) begin
                        q_pop          = 1'b1;
                        out_valid_in   = 1'b1;
                        out_in         = '0;
                        out_in.status  = q_head.status;
                        out_in.command = q_head.command;
                        out_in.last    = 1'b1;
                     end
                  end
                  CMD_RUN: begin
                     if (q_head.idx != '0) begin
                        q_pop    = 1'b1;
                        idx_in   = '0;
                        cnt_in   = q_head.idx;
                        cmd_in   = q_head.command;
                        state_in = BK_RUN;
                     end else if (out_free) begin
                        // accepted frame without data bytes
                        q_pop          = 1'b1;
                        out_valid_in   = 1'b1;
                        out_in         = '0;
                        out_in.status  = ST_ACCEPT;
                        out_in.command = q_head.command;
                        out_in.last    = 1'b1;
                     end
                  end
                  default: begin
                     q_pop = 1'b1;
                  end
               endcase
            end
         end
         BK_RUN: begin
            if (!rd_pend_ff) begin
               mem_re     = 1'b1;
               rd_pend_in = 1'b1;
            end else if (out_free) begin
               rd_pend_in        = 1'b0;
               out_valid_in      = 1'b1;
               out_in.status     = ST_ACCEPT;
               out_in.command    = cmd_ff;
               out_in.data_byte  = rd_data_ff;
               out_in.data_index = idx_ff;
               out_in.data_count = cnt_ff;
               out_in.byte_valid = 1'b1;
               out_in.last       = run_last;
               idx_in            = idx_ff + IDX_W'(1);
               if (run_last) begin
                  state_in = BK_IDLE;
               end
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

endmodule

/* rtl/modbus_ascii_frame_receiver.sv */
// top level of the modbus ascii slave frame receiver
`timescale 1ns / 1ps

// The receiver takes one item per cycle on the req_ side while its command
// queue (four entries) has room: a character, or a release of a pending
// message. The framer decodes hex pairs, checks the station address and the
// lrc, and queues store writes and frame outcomes. The result sequencer takes
// one queued store write per cycle while idle, puts out an exception or an
// empty accepted frame as one registered response, and plays back a frame's
// data byte by byte, each read into a register from the data store. Accepted
// frames block further characters until a release item arrives; exceptions
// and bad frames do not. Configuration writes on the csr_ port are registered.

module modbus_ascii_frame_receiver #(
   parameter int DATA_DEPTH = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  mbar_pkg::req_type req_data,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output mbar_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [7:0]        csr_wdata
);
   import mbar_pkg::*;

   logic    q_push;
   cmd_type q_entry;
   logic    q_pop;
   logic    q_full;
   logic    q_empty;
   cmd_type q_head;

   assign req_full = q_full;

   mbar_front #(
      .DATA_DEPTH(DATA_DEPTH)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_data (req_data),
      .q_full   (q_full),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .q_push   (q_push),
      .q_entry  (q_entry)
   );

   mbar_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_data(q_entry),
      .pop      (q_pop),
      .full     (q_full),
      .empty    (q_empty),
      .head     (q_head)
   );

   mbar_back #(
      .DATA_DEPTH(DATA_DEPTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .q_head   (q_head),
      .q_pop    (q_pop),
      .rsp_pop  (rsp_pop),
      .rsp_empty(rsp_empty),
      .rsp_data (rsp_data)
   );

endmodule
